/* src/fss_pkg.sv */
package fss_pkg;

  // scene store limit; indexes are 6 bits wide in any case
  localparam int MAX_SCENES = 64;
  localparam logic [6:0] SCENE_LIM = (MAX_SCENES < 64) ? 7'(MAX_SCENES) : 7'd64;

  // shortest hold and fade time in ms
  localparam logic [15:0] MIN_MS = 16'd10;

  localparam logic [7:0] LVL_MAX = 8'hFF;

  // serial divider geometry: quotient never exceeds eight bits
  localparam int DIV_NUM_W = 22;
  localparam int DIV_DEN_W = 14;
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE = 3'd5;

  typedef enum logic [1:0] {
    PH_FADE_IN  = 2'd0,
    PH_HOLD     = 2'd1,
    PH_FADE_OUT = 2'd2,
    PH_BLACK    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } fss_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] elapsed_ms;
    logic        run_enable;
    logic        view_active;
    logic        keep_fade;
  } fss_in_t;

  typedef struct packed {
    logic       level_write;
    logic [7:0] fade_level;
    logic       fade_on;
    logic       scene_load;
    logic [5:0] scene_index;
    logic       use_override;
    logic [1:0] phase_now;
  } fss_out_t;

endpackage

/* src/fss_in_if.sv */
interface fss_in_if import fss_pkg::*; ();
  logic    valid;
  logic    ready;
  fss_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/fss_out_if.sv */
interface fss_out_if import fss_pkg::*; ();
  logic     valid;
  logic     ready;
  fss_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/fade_slideshow_sequencer_unit.sv */
// Slideshow fade sequencer. Each input transaction is a frame tick, a start or a stop
// command and gives exactly one result transaction carrying the darkness level (when
// written), the scene load pulse, the scene index and the phase. The four phases run
// fade in, hold, fade out and black on a saturating millisecond timer. A transaction
// is evaluated and then held in the done state until the output register can take its
// result. The fade level during a fade (timer * 255 / fade) and the scene wrap at the
// end of a fade out (next index modulo the scene count) both go through one 8-step
// restoring divider, and the sequencer waits in its divide state until it is done.
// The input is ready again once the result is loaded; a result still waiting in the
// output register holds the next result back until it drains. The input is not ready
// while a transaction is being worked on; a finished result may still wait in the
// output register while the next transaction is taken.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata and must
// only change while the unit is idle.
module fade_slideshow_sequencer_unit import fss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fss_in_if.sink               in_ch,
  fss_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  // sequencer state
  fss_state_t state_r, state_nxt;

  // configuration
  logic [15:0] hold_r;
  logic [13:0] fade_r;
  logic [12:0] black_r;
  logic [6:0]  count_r;
  logic [5:0]  first_r;
  logic        ovr_r;

  // slideshow state
  phase_t      phase_r, phase_nxt;
  logic [31:0] timer_r, timer_nxt;
  logic [5:0]  scene_r, scene_nxt;
  logic        was_r, was_nxt;
  logic        paused_r, paused_nxt;
  logic        active_r, active_nxt;

  // captured transaction, pending result and output register
  fss_in_t     item_r, item_nxt;
  fss_out_t    pend_r, pend_nxt;
  logic        inv_r, inv_nxt;
  logic        mod_r, mod_nxt;
  fss_out_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // shared divider
  logic                 div_go;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_STEPS-1:0] div_q;
  logic [DIV_DEN_W-1:0] div_rem;

  // evaluation helpers
  logic [6:0]  cnt_eff;
  logic [6:0]  cnt_m1;
  logic [13:0] fade_eff;
  logic [15:0] hold_eff;
  phase_t      base_phase;
  logic [31:0] base_time;
  logic [32:0] sum;
  logic [31:0] sat;
  logic [21:0] prod;

  fss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // configuration writes, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= 16'd6000;
      fade_r  <= 14'd1200;
      black_r <= 13'd400;
      count_r <= '0;
      first_r <= '0;
      ovr_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD:     hold_r  <= cfg_wdata;
        REG_FADE:     fade_r  <= cfg_wdata[13:0];
        REG_BLACK:    black_r <= cfg_wdata[12:0];
        REG_COUNT:    count_r <= cfg_wdata[6:0];
        REG_FIRST:    first_r <= cfg_wdata[5:0];
        REG_OVERRIDE: ovr_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective settings
  assign cnt_eff  = (count_r > SCENE_LIM) ? SCENE_LIM : count_r;
  assign cnt_m1   = cnt_eff - 7'd1;
  assign fade_eff = ({2'b00, fade_r} < MIN_MS) ? MIN_MS[13:0] : fade_r;
  assign hold_eff = (hold_r < MIN_MS) ? MIN_MS : hold_r;

  // re-enable restarts at fade in with a cleared timer
  assign base_phase = was_r ? phase_r : PH_FADE_IN;
  assign base_time  = was_r ? timer_r : 32'd0;

  // saturating timer advance
  assign sum = {1'b0, base_time} + {17'd0, item_r.elapsed_ms};
  assign sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  // timer * 255, only used while the timer is below the fade time
  assign prod = {sat[13:0], 8'd0} - {8'd0, sat[13:0]};

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    timer_nxt     = timer_r;
    scene_nxt     = scene_r;
    was_nxt       = was_r;
    paused_nxt    = paused_r;
    active_nxt    = active_r;
    item_nxt      = item_r;
    pend_nxt      = pend_r;
    inv_nxt       = inv_r;
    mod_nxt       = mod_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    div_go        = 1'b0;
    div_num       = '0;
    div_den       = '0;

    // output register drains independently
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          item_nxt  = in_ch.data;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        pend_nxt  = '0;
        inv_nxt   = 1'b0;
        mod_nxt   = 1'b0;
        state_nxt = ST_DONE;
        unique case (item_r.cmd)
          CMD_START: begin
            if (cnt_eff == 7'd0) begin
              scene_nxt = '0;
            end else if ({1'b0, first_r} > cnt_m1) begin
              scene_nxt = cnt_m1[5:0];
            end else begin
              scene_nxt = first_r;
            end
            timer_nxt  = '0;
            phase_nxt  = PH_FADE_IN;
            was_nxt    = item_r.run_enable;
            paused_nxt = !item_r.view_active;
            active_nxt = 1'b1;
            pend_nxt.scene_load  = ovr_r || (cnt_eff != 7'd0);
            pend_nxt.level_write = 1'b1;
            pend_nxt.fade_level  = item_r.view_active ? LVL_MAX : 8'd0;
          end
          CMD_STOP: begin
            pend_nxt.level_write = !item_r.keep_fade;
            paused_nxt = 1'b0;
            active_nxt = 1'b0;
          end
          CMD_TICK: begin
            if (active_r && cnt_eff != 7'd0) begin
              if (!item_r.run_enable) begin
                // disabled: clear once, freeze progress
                if (was_r) begin
                  pend_nxt.level_write = 1'b1;
                  was_nxt = 1'b0;
                end
              end else begin
                was_nxt   = 1'b1;
                phase_nxt = base_phase;
                timer_nxt = base_time;
                if (!item_r.view_active) begin
                  // view suspended: clear once, timer held
                  if (!paused_r) begin
                    pend_nxt.level_write = 1'b1;
                    paused_nxt = 1'b1;
                  end
                end else begin
                  paused_nxt = 1'b0;
                  pend_nxt.level_write = 1'b1;
                  timer_nxt = sat;
                  unique case (base_phase)
                    PH_FADE_IN: begin
                      if (sat >= {18'd0, fade_eff}) begin
                        phase_nxt = PH_HOLD;
                        timer_nxt = '0;
                      end else begin
                        div_go    = 1'b1;
                        div_num   = prod;
                        div_den   = fade_eff;
                        inv_nxt   = 1'b1;
                        state_nxt = ST_DIV;
                      end
                    end
                    PH_HOLD: begin
                      if (sat >= {16'd0, hold_eff}) begin
                        phase_nxt = PH_FADE_OUT;
                        timer_nxt = '0;
                      end
                    end
                    PH_FADE_OUT: begin
                      if (sat >= {18'd0, fade_eff}) begin
                        // end of fade out: fully black, wrap to the next scene
                        pend_nxt.fade_level = LVL_MAX;
                        pend_nxt.scene_load = 1'b1;
                        phase_nxt = PH_BLACK;
                        timer_nxt = '0;
                        div_go    = 1'b1;
                        div_num   = {15'd0, 7'({1'b0, scene_r} + 7'd1)};
                        div_den   = {7'd0, cnt_eff};
                        mod_nxt   = 1'b1;
                        state_nxt = ST_DIV;
                      end else begin
                        div_go    = 1'b1;
                        div_num   = prod;
                        div_den   = fade_eff;
                        state_nxt = ST_DIV;
                      end
                    end
                    PH_BLACK: begin
                      pend_nxt.fade_level = LVL_MAX;
                      if (sat >= {19'd0, black_r}) begin
                        phase_nxt = PH_FADE_IN;
                        timer_nxt = '0;
                      end
                    end
                    default: ;
                  endcase
                end
              end
            end
          end
          default: ;
        endcase
        pend_nxt.scene_index  = scene_nxt;
        pend_nxt.use_override = pend_nxt.scene_load && ovr_r;
        pend_nxt.phase_now    = 2'(phase_nxt);
      end

      ST_DIV: begin
        if (div_done) begin
          if (mod_r) begin
            scene_nxt            = div_rem[5:0];
            pend_nxt.scene_index = div_rem[5:0];
          end else begin
            pend_nxt.fade_level = inv_r ? (LVL_MAX - div_q) : div_q;
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt         = pend_r;
          out_nxt.fade_on = pend_r.level_write && (pend_r.fade_level != 8'd0);
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FADE_IN;
      timer_r     <= '0;
      scene_r     <= '0;
      was_r       <= 1'b0;
      paused_r    <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      scene_r     <= scene_nxt;
      was_r       <= was_nxt;
      paused_r    <= paused_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    pend_r <= pend_nxt;
    inv_r  <= inv_nxt;
    mod_r  <= mod_nxt;
    out_r  <= out_nxt;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // the divider only runs while the sequencer waits on it
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == ST_DIV)
    else $error("divider busy outside its wait state");

  // an accepted transaction is evaluated on the next cycle
  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_EVAL)
    else $error("accepted transaction not evaluated");

  // fade pass enabled only with a written, nonzero level
  a_fade_on_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.fade_on |->
      out_ch.data.level_write && out_ch.data.fade_level != 8'd0)
    else $error("fade_on without a written level");

  // override flag only comes with a scene load
  a_override_with_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.use_override |-> out_ch.data.scene_load)
    else $error("use_override without scene_load");

endmodule

/* src/fss_div.sv */
module fss_div import fss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 busy,
  output logic                 done,
  output logic [DIV_STEPS-1:0] quot,
  output logic [DIV_DEN_W-1:0] rem
);

  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_STEPS-1:0] low_r, low_nxt;
  logic [DIV_STEPS-1:0] q_r, q_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fit;

  // one restoring step per cycle; partial remainder stays below the divisor
  assign trial = {rem_r, low_r[DIV_STEPS-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fit   = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[DIV_NUM_W-1:DIV_STEPS];
      low_nxt  = dividend[DIV_STEPS-1:0];
      den_nxt  = divisor;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      low_nxt = {low_r[DIV_STEPS-2:0], 1'b0};
      q_nxt   = {q_r[DIV_STEPS-2:0], fit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule
